>>> sv/skm_pkg.sv
// Shared types, register indexes and character helpers for the keyword matcher.
package skm_pkg;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } skm_state_t;

    // Input command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_FEED = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] REG_CASE_SENSITIVE = 3'd0;
    localparam logic [2:0] REG_ENTRY_COUNT    = 3'd1;
    localparam logic [2:0] REG_SEP_A          = 3'd2;
    localparam logic [2:0] REG_SEP_B          = 3'd3;
    localparam logic [2:0] REG_SEP_C          = 3'd4;
    localparam logic [2:0] REG_SEP_D          = 3'd5;

    // ASCII letter bounds and case offset
    localparam logic [7:0] UPPER_A     = 8'd65;
    localparam logic [7:0] UPPER_Z     = 8'd90;
    localparam logic [7:0] LOWER_A     = 8'd97;
    localparam logic [7:0] LOWER_Z     = 8'd122;
    localparam logic [7:0] CASE_OFFSET = 8'd32;

    // Controller to datapath commands
    typedef struct packed {
        logic start_feed;
        logic load_wr;
        logic scan_step;
        logic finish;
    } skm_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic scan_done;
        logic is_sep;
        logic out_busy;
    } skm_status_t;

    // Table character t against stream byte b, optional letter case folding
    function automatic logic chars_match(logic [7:0] t, logic [7:0] b, logic cs);
        logic m;
        m = 1'b0;
        if (t == b) begin
            m = 1'b1;
        end else if (!cs) begin
            if (b >= UPPER_A && b <= UPPER_Z) begin
                m = (t == 8'(b + CASE_OFFSET));
            end else if (b >= LOWER_A && b <= LOWER_Z) begin
                m = (t == 8'(b - CASE_OFFSET));
            end
        end
        return m;
    endfunction

endpackage

>>> sv/skm_ram.sv
// Generic simple dual port RAM with registered read data.
module skm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/skm_ctrl.sv
// Controller state machine: sequences load, window scan and result hand-off.
module skm_ctrl import skm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_command,
    input  skm_status_t status,
    output logic        s_ready,
    output skm_cmd_t    cmd
);

    skm_state_t state_reg, state_next;
    logic       fin_blocked;

    assign fin_blocked = status.is_sep && status.out_busy;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_command == CMD_FEED) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (status.scan_done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!fin_blocked) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        s_ready        = 1'b0;
        cmd.start_feed = 1'b0;
        cmd.load_wr    = 1'b0;
        cmd.scan_step  = 1'b0;
        cmd.finish     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready        = 1'b1;
                cmd.start_feed = s_valid && (s_command == CMD_FEED);
                cmd.load_wr    = s_valid && (s_command == CMD_LOAD);
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
            end
            ST_FIN: begin
                cmd.finish = !fin_blocked;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> sv/skm_dp.sv
// Datapath: config registers, keyword table, window registers and result register.
module skm_dp import skm_pkg::*; #(
    parameter int ENTRIES = 16,
    parameter int MAX_LEN = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  skm_cmd_t    cmd,
    output skm_status_t status,
    input  logic [3:0]  s_entry,
    input  logic [3:0]  s_position,
    input  logic [7:0]  s_char_value,
    input  logic        cfg_valid,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_found,
    output logic [3:0]  m_entry_index
);

    localparam int ENT_W  = $clog2(ENTRIES);
    localparam int LEN_W  = $clog2(MAX_LEN);
    localparam int CP_W   = $clog2(MAX_LEN + 1);
    localparam int WIN_W  = ($clog2(ENTRIES + 1) > 5) ? $clog2(ENTRIES + 1) : 5;
    localparam int ADDR_W = ENT_W + LEN_W;
    localparam int DEPTH  = ENTRIES * (1 << LEN_W);
    localparam logic [WIN_W-1:0] ENT_LIM = WIN_W'(ENTRIES);
    localparam logic [CP_W-1:0]  LEN_LIM = CP_W'(MAX_LEN);

    // Configuration registers
    logic             cs_reg, cs_next;
    logic [4:0]       ecount_reg, ecount_next;
    logic [7:0]       sep_reg [4];
    logic [7:0]       sep_next [4];

    // Window state
    logic [WIN_W-1:0] wlow_reg, wlow_next;
    logic [WIN_W-1:0] whigh_reg, whigh_next;
    logic [CP_W-1:0]  cpos_reg, cpos_next;
    logic [3:0]       match_reg, match_next;

    // Scan state
    logic             found_reg, found_next;
    logic             sep_hit_reg, sep_hit_next;
    logic [7:0]       ch_reg, ch_next;
    logic [WIN_W-1:0] issue_reg, issue_next;
    logic             pend_reg, pend_next;
    logic [WIN_W-1:0] pidx_reg, pidx_next;

    // Result register
    logic             m_valid_reg, m_valid_next;
    logic             m_found_reg, m_found_next;
    logic [3:0]       m_eidx_reg, m_eidx_next;

    logic [WIN_W-1:0] stop;
    logic             issue_ok;
    logic [7:0]       rdata;
    logic [7:0]       tchar;
    logic             t_zero;
    logic             t_match;
    logic             brk;
    logic             sep_now;
    logic             ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic             ram_re;
    logic [ADDR_W-1:0] ram_raddr;

    // Keyword table
    skm_ram #(
        .WIDTH(8),
        .DEPTH(DEPTH)
    ) u_table (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(s_char_value),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(rdata)
    );

    // Table write on an in-range load
    assign ram_we = cmd.load_wr && (32'(s_entry) < ENTRIES) && (32'(s_position) < MAX_LEN);
    assign ram_waddr = {ENT_W'(s_entry), LEN_W'(s_position)};

    // Scan bound and table read
    assign stop      = (whigh_reg < ENT_LIM) ? whigh_reg : ENT_LIM;
    assign issue_ok  = issue_reg < stop;
    assign ram_re    = cmd.scan_step && issue_ok;
    assign ram_raddr = {issue_reg[ENT_W-1:0], cpos_reg[LEN_W-1:0]};

    // Evaluate the entry read last cycle; past MAX_LEN reads as terminator
    assign tchar   = (cpos_reg >= LEN_LIM) ? 8'd0 : rdata;
    assign t_zero  = (tchar == 8'd0);
    assign t_match = chars_match(tchar, ch_reg, cs_reg);
    assign brk     = pend_reg && !t_zero && !t_match && found_reg;

    // Separator detect, zero slots unused
    always_comb begin
        sep_now = 1'b0;
        for (int k = 0; k < 4; k++) begin
            if (sep_reg[k] != 8'd0 && s_char_value == sep_reg[k]) begin
                sep_now = 1'b1;
            end
        end
    end

    assign status.scan_done = brk || (!pend_reg && !issue_ok);
    assign status.is_sep    = sep_hit_reg;
    assign status.out_busy  = m_valid_reg && !m_ready;

    // Next state of all datapath registers
    always_comb begin
        cs_next      = cs_reg;
        ecount_next  = ecount_reg;
        sep_next     = sep_reg;
        wlow_next    = wlow_reg;
        whigh_next   = whigh_reg;
        cpos_next    = cpos_reg;
        match_next   = match_reg;
        found_next   = found_reg;
        sep_hit_next = sep_hit_reg;
        ch_next      = ch_reg;
        issue_next   = issue_reg;
        pend_next    = pend_reg;
        pidx_next    = pidx_reg;
        m_valid_next = m_valid_reg;
        m_found_next = m_found_reg;
        m_eidx_next  = m_eidx_reg;

        // Result transaction leaves
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // Feed accepted: latch byte, separator becomes terminator
        if (cmd.start_feed) begin
            issue_next   = wlow_reg;
            pend_next    = 1'b0;
            found_next   = 1'b0;
            sep_hit_next = sep_now;
            ch_next      = sep_now ? 8'd0 : s_char_value;
        end

        // One entry issued and one evaluated per cycle
        if (cmd.scan_step) begin
            pend_next = issue_ok && !brk;
            pidx_next = issue_reg;
            if (issue_ok) begin
                issue_next = WIN_W'(issue_reg + 1'b1);
            end
            if (pend_reg) begin
                if (t_zero) begin
                    if (sep_hit_reg) begin
                        match_next = 4'(pidx_reg);
                        found_next = 1'b1;
                    end else begin
                        wlow_next = WIN_W'(pidx_reg + 1'b1);
                    end
                end else if (t_match) begin
                    if (!found_reg) begin
                        wlow_next = pidx_reg;
                    end
                    found_next = 1'b1;
                end else if (found_reg) begin
                    whigh_next = pidx_reg;
                end else begin
                    wlow_next = WIN_W'(pidx_reg + 1'b1);
                end
            end
        end

        // Finish: emit result and restart, or advance position
        if (cmd.finish) begin
            if (sep_hit_reg) begin
                m_valid_next = 1'b1;
                m_found_next = found_reg;
                m_eidx_next  = found_reg ? match_reg : 4'd0;
                match_next   = found_reg ? match_reg : 4'd0;
                wlow_next    = '0;
                whigh_next   = WIN_W'(ecount_reg);
                cpos_next    = '0;
            end else if (cpos_reg < LEN_LIM) begin
                cpos_next = CP_W'(cpos_reg + 1'b1);
            end
        end

        // Configuration write
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_CASE_SENSITIVE: cs_next = cfg_data[0];
                REG_ENTRY_COUNT: begin
                    ecount_next = cfg_data[4:0];
                    wlow_next   = '0;
                    whigh_next  = WIN_W'(cfg_data[4:0]);
                    cpos_next   = '0;
                end
                REG_SEP_A: sep_next[0] = cfg_data;
                REG_SEP_B: sep_next[1] = cfg_data;
                REG_SEP_C: sep_next[2] = cfg_data;
                REG_SEP_D: sep_next[3] = cfg_data;
                default: cs_next = cs_reg;
            endcase
        end
    end

    // Control registers with reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cs_reg      <= 1'b1;
            ecount_reg  <= '0;
            for (int k = 0; k < 4; k++) begin
                sep_reg[k] <= '0;
            end
            wlow_reg    <= '0;
            whigh_reg   <= '0;
            cpos_reg    <= '0;
            match_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            cs_reg      <= cs_next;
            ecount_reg  <= ecount_next;
            sep_reg     <= sep_next;
            wlow_reg    <= wlow_next;
            whigh_reg   <= whigh_next;
            cpos_reg    <= cpos_next;
            match_reg   <= match_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        found_reg   <= found_next;
        sep_hit_reg <= sep_hit_next;
        ch_reg      <= ch_next;
        issue_reg   <= issue_next;
        pidx_reg    <= pidx_next;
        m_found_reg <= m_found_next;
        m_eidx_reg  <= m_eidx_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_found       = m_found_reg;
    assign m_entry_index = m_eidx_reg;

endmodule

>>> sv/sorted_keyword_token_matcher.sv
// Top level: sorted keyword matcher, controller plus datapath.
//
//  channel   direction  handshake              payload
//  s_        in         s_valid / s_ready      s_command s_entry s_position s_char_value
//  m_        out        m_valid / m_ready      m_found m_entry_index
//  cfg_      in         cfg_valid / cfg_ready  cfg_index cfg_data
//
// A load transaction is taken in ST_IDLE and does not leave it. A feed transaction checks
// one window entry per cycle on the single table read port until all entries of the window
// are checked or the window closes, none if it is empty; it then returns through ST_FIN.
// Reset is synchronous and active low; the keyword table is not cleared
// and holds nothing defined until loaded. A result waiting on m_ready stalls only the
// finish of the next separator feed; loads and other feeds proceed.
module sorted_keyword_token_matcher import skm_pkg::*; #(
    parameter int ENTRIES = 16,
    parameter int MAX_LEN = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_command,
    input  logic [3:0] s_entry,
    input  logic [3:0] s_position,
    input  logic [7:0] s_char_value,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_found,
    output logic [3:0] m_entry_index,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data
);

    skm_cmd_t    cmd;
    skm_status_t status;

    // Configuration is always taken
    assign cfg_ready = 1'b1;

    skm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_command(s_command),
        .status   (status),
        .s_ready  (s_ready),
        .cmd      (cmd)
    );

    skm_dp #(
        .ENTRIES(ENTRIES),
        .MAX_LEN(MAX_LEN)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .s_entry      (s_entry),
        .s_position   (s_position),
        .s_char_value (s_char_value),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_found      (m_found),
        .m_entry_index(m_entry_index)
    );

endmodule

>>> sv/skm_checker.sv
// Port level checks for the keyword matcher, bound to the top level.
module skm_checker import skm_pkg::*; (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       s_command,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_found,
    input logic [3:0] m_entry_index
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_found) && $stable(m_entry_index))
        else $error("result changed while stalled");

    // Miss reports index zero
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_entry_index == 4'd0)
        else $error("miss with nonzero index");

    // No result right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A load transaction leaves the block ready
    a_load_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_command == CMD_LOAD |=> s_ready)
        else $error("not ready after load");

endmodule

bind sorted_keyword_token_matcher skm_checker u_skm_checker (.*);

>>> dv/sorted_keyword_token_matcher_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sorted keyword token matcher: directed and random token streams.
module sorted_keyword_token_matcher_tb import skm_pkg::*;;

    localparam int ENTRIES      = 16;
    localparam int MAX_LEN      = 16;
    localparam int DRAIN_CYCLES = 40;   // longest feed scan plus margin
    localparam logic [2:0] REG_SPARE_6 = 3'd6;
    localparam logic [2:0] REG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic       found;
        logic [3:0] index;
    } match_t;

    logic       aclk          = 1'b0;
    logic       aresetn       = 1'b0;
    logic       s_valid       = 1'b0;
    logic       s_ready;
    logic       s_command     = CMD_LOAD;
    logic [3:0] s_entry       = 4'd0;
    logic [3:0] s_position    = 4'd0;
    logic [7:0] s_char_value  = 8'd0;
    logic       m_valid;
    logic       m_ready       = 1'b0;
    logic       m_found;
    logic [3:0] m_entry_index;
    logic       cfg_valid     = 1'b0;
    logic       cfg_ready;
    logic [2:0] cfg_index     = REG_CASE_SENSITIVE;
    logic [7:0] cfg_data      = 8'd0;

    // Predictor state: table copy, registers, search window
    logic [7:0] kw_table [ENTRIES][MAX_LEN];
    logic       case_exact;
    logic [4:0] entry_limit;
    logic [7:0] sep_byte [4];
    int         win_lo;
    int         win_hi;
    int         tok_pos;
    logic [3:0] last_hit;
    match_t     expected_matches [$];
    string      words [ENTRIES];
    int         errors      = 0;
    int         items_sent  = 0;
    bit         quiet_tail  = 1'b0;

    sorted_keyword_token_matcher dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_entry       (s_entry),
        .s_position    (s_position),
        .s_char_value  (s_char_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_found       (m_found),
        .m_entry_index (m_entry_index),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Run limit
    initial begin
        #4_000_000;
        $display("sorted_keyword_token_matcher: mismatch");
        $finish;
    end

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t ns  %s: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    // Letter case folding keys off the stream byte only
    function automatic bit bytes_match(logic [7:0] t, logic [7:0] b);
        if (t == b) return 1'b1;
        if (!case_exact) begin
            if (b >= UPPER_A && b <= UPPER_Z) return t == b + CASE_OFFSET;
            if (b >= LOWER_A && b <= LOWER_Z) return t == b - CASE_OFFSET;
        end
        return 1'b0;
    endfunction

    task automatic restart_window();
        win_lo  = 0;
        win_hi  = int'(entry_limit);
        tok_pos = 0;
    endtask

    task automatic model_reset();
        case_exact  = 1'b1;
        entry_limit = 5'd0;
        foreach (sep_byte[k]) sep_byte[k] = 8'd0;
        last_hit = 4'd0;
        restart_window();
    endtask

    task automatic apply_reg(logic [2:0] idx, logic [7:0] data);
        case (idx)
            REG_CASE_SENSITIVE: case_exact = data[0];
            REG_ENTRY_COUNT: begin
                entry_limit = data[4:0];
                restart_window();
            end
            REG_SEP_A: sep_byte[0] = data;
            REG_SEP_B: sep_byte[1] = data;
            REG_SEP_C: sep_byte[2] = data;
            REG_SEP_D: sep_byte[3] = data;
            default: ;
        endcase
    endtask

    // Window narrowing for one accepted transaction; queues the match a separator yields
    task automatic predict_item(logic cmd, logic [3:0] ent, logic [3:0] pos, logic [7:0] ch);
        logic [7:0] b;
        logic [7:0] t;
        bit         is_sep;
        bit         hit;
        int         stop;
        match_t     m;
        if (cmd == CMD_LOAD) begin
            kw_table[ent][pos] = ch;
            return;
        end
        is_sep = 1'b0;
        hit    = 1'b0;
        foreach (sep_byte[k]) begin
            if (sep_byte[k] != 8'd0 && ch == sep_byte[k]) is_sep = 1'b1;
        end
        b    = is_sep ? 8'd0 : ch;
        stop = (win_hi < ENTRIES) ? win_hi : ENTRIES;
        for (int i = win_lo; i < stop; i++) begin
            // past the last stored column everything reads as the terminator
            t = (tok_pos < MAX_LEN) ? kw_table[i][tok_pos] : 8'd0;
            if (t == 8'd0) begin
                if (is_sep) begin
                    last_hit = 4'(i);
                    hit      = 1'b1;
                end else begin
                    win_lo = i + 1;
                end
            end else if (bytes_match(t, b)) begin
                if (!hit) win_lo = i;
                hit = 1'b1;
            end else if (hit) begin
                win_hi = i;
                break;
            end else begin
                win_lo = i + 1;
            end
        end
        if (is_sep) begin
            if (!hit) last_hit = 4'd0;
            m.found = hit;
            m.index = hit ? last_hit : 4'd0;
            expected_matches.push_back(m);
            restart_window();
        end else if (tok_pos < MAX_LEN) begin
            tok_pos++;
        end
    endtask

    // Send one transaction; valid is left high so back-to-back items need no toggle
    task automatic send_item(logic cmd, logic [3:0] ent, logic [3:0] pos, logic [7:0] ch);
        int gap;
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 16);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_command    <= cmd;
        s_entry      <= ent;
        s_position   <= pos;
        s_char_value <= ch;
        do @(posedge aclk); while (!s_ready);
        predict_item(cmd, ent, pos, ch);
        items_sent++;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        apply_reg(idx, data);
    endtask

    // Drain all pending results, then let any non-result scan finish
    task automatic wait_for_idle();
        s_valid <= 1'b0;
        while (expected_matches.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic configure(logic cs, logic [4:0] count, logic [7:0] sa, logic [7:0] sb,
                             logic [7:0] sc, logic [7:0] sd);
        wait_for_idle();
        write_reg(REG_CASE_SENSITIVE, {7'd0, cs});
        write_reg(REG_ENTRY_COUNT, {3'd0, count});
        write_reg(REG_SEP_A, sa);
        write_reg(REG_SEP_B, sb);
        write_reg(REG_SEP_C, sc);
        write_reg(REG_SEP_D, sd);
        cfg_valid <= 1'b0;
    endtask

    // Every table byte gets written: keyword, terminator, random fill
    task automatic load_table();
        string      w;
        logic [7:0] c;
        for (int e = 0; e < ENTRIES; e++) begin
            w = words[e];
            for (int p = 0; p < MAX_LEN; p++) begin
                if (p < w.len()) c = w[p];
                else if (p == w.len()) c = 8'd0;
                else c = 8'($urandom_range(0, 255));
                send_item(CMD_LOAD, 4'(e), 4'(p), c);
            end
        end
    endtask

    task automatic feed_string(string str, logic [7:0] sep);
        for (int i = 0; i < str.len(); i++)
            send_item(CMD_FEED, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), str[i]);
        send_item(CMD_FEED, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), sep);
    endtask

    // Random keyword set, short words over a small alphabet, sorted bytewise
    task automatic make_random_words();
        string      w;
        logic [7:0] c;
        int         len;
        int         j;
        for (int e = 0; e < ENTRIES; e++) begin
            if (e > 0 && $urandom_range(0, 7) == 0) begin
                w = words[e - 1];
            end else begin
                len = ($urandom_range(0, 9) == 0) ? MAX_LEN : $urandom_range(0, 5);
                w = "";
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 9) == 0) c = 8'(UPPER_A + $urandom_range(0, 2));
                    else c = 8'(LOWER_A + $urandom_range(0, 3));
                    w = $sformatf("%s%c", w, c);
                end
            end
            words[e] = w;
        end
        for (int i = 1; i < ENTRIES; i++) begin
            w = words[i];
            j = i - 1;
            while (j >= 0 && words[j] > w) begin
                words[j + 1] = words[j];
                j--;
            end
            words[j + 1] = w;
        end
    endtask

    function automatic logic [7:0] pick_sep(bit allow_unused);
        case ($urandom_range(allow_unused ? 0 : 1, 5))
            0:       return 8'd0;
            1:       return 8'd32;
            2:       return 8'd44;
            3:       return 8'd255;
            4:       return 8'($urandom_range(1, 255));
            default: return 8'd10;
        endcase
    endfunction

    // One token: mostly a keyword (maybe case-flipped, cut short or extended), some noise
    task automatic feed_token();
        string      tok;
        logic [7:0] c;
        logic [7:0] seps [$];
        int         kind;
        int         active;
        int         n;
        active = (entry_limit < ENTRIES) ? int'(entry_limit) : ENTRIES;
        kind   = $urandom_range(0, 19);
        tok    = "";
        if (kind < 12 && active > 0) begin
            tok = words[$urandom_range(0, active - 1)];
            if (kind >= 10 && tok.len() > 0) begin
                tok = tok.substr(0, tok.len() - 2);
            end else if (kind == 9) begin
                c = 8'(LOWER_A + $urandom_range(0, 3));
                tok = $sformatf("%s%c", tok, c);
            end
        end else if (kind < 16) begin
            // raw bytes, may run past the longest keyword
            n = $urandom_range(1, 20);
            for (int i = 0; i < n; i++)
                send_item(CMD_FEED, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                          8'($urandom_range(0, 255)));
        end else if (kind == 16) begin
            send_item(CMD_LOAD, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                      8'($urandom_range(0, 255)));
            return;
        end
        for (int i = 0; i < tok.len(); i++) begin
            c = tok[i];
            if (((c >= UPPER_A && c <= UPPER_Z) || (c >= LOWER_A && c <= LOWER_Z))
                    && $urandom_range(0, 2) == 0)
                c = c ^ CASE_OFFSET;
            send_item(CMD_FEED, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), c);
        end
        foreach (sep_byte[k]) begin
            if (sep_byte[k] != 8'd0) seps.push_back(sep_byte[k]);
        end
        if (seps.size() > 0)
            send_item(CMD_FEED, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                      seps[$urandom_range(0, seps.size() - 1)]);
    endtask

    // Reset defaults: no separators and no entries, so feeds produce nothing
    task automatic test_reset_state();
        send_item(CMD_FEED, 4'd0, 4'd0, 8'd0);
        send_item(CMD_FEED, 4'd15, 4'd15, 8'd255);
        send_item(CMD_FEED, 4'd5, 4'd10, 8'd32);
    endtask

    task automatic load_directed_table();
        words = '{"", "a", "ab", "ab", "abc", "b", "ba", "bcd",
                  "c", "cab", "d", "da", "dd", "e", "ea", "eeeeeeeeeeeeeeee"};
        load_table();
    endtask

    task automatic test_directed_matches();
        configure(1'b1, 5'd16, 8'd32, 8'd255, 8'd0, 8'd44);
        feed_string("", 8'd32);          // empty token hits the empty keyword
        feed_string("ab", 8'd32);        // duplicate keywords, last one reported
        feed_string("AB", 8'd255);       // exact compare misses
        feed_string("zz", 8'd44);        // past every keyword
        feed_string("\001", 8'd44);
        send_item(CMD_FEED, 4'd0, 4'd0, 8'd0);   // zero byte: unused slot, not a separator
        send_item(CMD_FEED, 4'd0, 4'd0, 8'd44);
        configure(1'b0, 5'd16, 8'd32, 8'd255, 8'd0, 8'd44);
        feed_string("AB", 8'd44);        // folded
        feed_string("cAB", 8'd32);
        // unused register indexes change nothing
        wait_for_idle();
        write_reg(REG_SPARE_6, 8'hFF);
        write_reg(REG_SPARE_7, 8'h20);
        cfg_valid <= 1'b0;
        feed_string("d", 8'd32);
        configure(1'b1, 5'd0, 8'd32, 8'd0, 8'd0, 8'd0);
        feed_string("a", 8'd32);         // empty window
    endtask

    task automatic test_random_traffic();
        int target;
        for (int p = 0; p < 6; p++) begin
            if (p == 5) quiet_tail = 1'b1;
            case (p)
                0: configure(1'b0, 5'd16, pick_sep(0), pick_sep(1), pick_sep(1), pick_sep(1));
                1: configure(1'b1, 5'd16, pick_sep(0), pick_sep(1), pick_sep(1), pick_sep(1));
                2: configure(1'b0, 5'($urandom_range(2, 15)), pick_sep(0), pick_sep(1),
                             pick_sep(1), pick_sep(1));
                3: configure(1'b1, 5'd1, pick_sep(0), pick_sep(1), pick_sep(1), pick_sep(1));
                4: configure(1'b0, 5'd0, pick_sep(0), pick_sep(1), pick_sep(1), pick_sep(1));
                default: configure(1'b0, 5'd16, pick_sep(0), pick_sep(1), pick_sep(1),
                                   pick_sep(1));
            endcase
            if (p % 2 == 0) begin
                make_random_words();
                load_table();
            end
            target = items_sent + 120;
            while (items_sent < target) feed_token();
        end
    endtask

    // Result side: random stall bursts, none in the tail phase
    initial begin : result_sink
        int n;
        @(posedge aclk);
        forever begin
            if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                n = $urandom_range(1, 16);
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1'b1;
            n = $urandom_range(1, 24);
            repeat (n) @(posedge aclk);
        end
    end

    // Compare each result transaction with the oldest expected match
    always @(posedge aclk) begin : result_check
        match_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_matches.size() == 0) begin
                report_mismatch("unexpected result, found", m_found, 0);
            end else begin
                want = expected_matches.pop_front();
                if (m_found !== want.found)
                    report_mismatch("found", m_found, want.found);
                if (m_entry_index !== want.index)
                    report_mismatch("entry_index", m_entry_index, want.index);
            end
        end
    end

    initial begin : main_sequence
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        model_reset();
        test_reset_state();
        load_directed_table();
        test_directed_matches();
        test_random_traffic();
        wait_for_idle();
        if (errors == 0) begin
            $display("sorted_keyword_token_matcher: match");
        end else begin
            $display("sorted_keyword_token_matcher: mismatch");
        end
        $finish;
    end

endmodule
